// ----- sv/actuator_response_deframer_top_defines.svh -----
// Assertion macros shared by the deframer checks
`ifndef ACTUATOR_RESPONSE_DEFRAMER_TOP_DEFINES_SVH
`define ACTUATOR_RESPONSE_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ARD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled in reset
`define ARD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- sv/ard_pkg.sv -----
// Shared types and constants of the actuator response deframer
package ard_pkg;

  localparam int PENDING_DEPTH = 8;
  localparam int PEND_PTR_W    = $clog2(PENDING_DEPTH);
  localparam int PEND_CNT_W    = $clog2(PENDING_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_R   = 8'h52;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] LET_O    = 8'h4F;
  localparam logic [7:0] LET_T    = 8'h54;
  localparam logic [7:0] LET_E    = 8'h45;
  localparam logic [7:0] LET_C    = 8'h43;
  localparam logic [7:0] LET_S    = 8'h53;
  localparam logic [7:0] LET_G    = 8'h47;

  localparam logic [3:0] EV_ACK_O     = 4'd0;
  localparam logic [3:0] EV_ACK_T     = 4'd1;
  localparam logic [3:0] EV_ACK_E     = 4'd2;
  localparam logic [3:0] EV_ACK_C     = 4'd3;
  localparam logic [3:0] EV_ACK_S     = 4'd4;
  localparam logic [3:0] EV_DATA      = 4'd5;
  localparam logic [3:0] EV_FRAME_ERR = 4'd6;
  localparam logic [3:0] EV_UNMATCHED = 4'd7;
  localparam logic [3:0] EV_EMPTY     = 4'd8;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_MEMORY = 3'd1;
  localparam logic [2:0] KIND_SPEED  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_LETTER  = 7'b0000010,
    PH_ACKB    = 7'b0000100,
    PH_LENLO   = 7'b0001000,
    PH_LENHI   = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_TRAIL   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       is_note;
    logic [2:0] kind;
    logic [7:0] data;
    logic       is_r;
    logic       is_ack;
    logic       letter_ok;
    logic       letter_g;
    logic [3:0] ack_ev;
  } cmd_t;

endpackage

// ----- sv/ard_front.sv -----
// Front end: accepts transactions and classifies bytes and request notes
module ard_front
  import ard_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [2:0] request_kind,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  logic kind_ok;

  assign kind_ok  = (request_kind >= KIND_MEMORY) && (request_kind <= KIND_STATUS);
  assign in_ready = !q_full;
  // notes of a kind outside KIND_MEMORY..KIND_STATUS carry no work and never enter the queue
  assign q_push   = in_valid && !q_full && (!req_type || kind_ok);

  always_comb begin
    q_data           = '0;
    q_data.is_note   = req_type;
    q_data.kind      = request_kind;
    q_data.data      = rx_byte;
    q_data.is_r      = (rx_byte == BYTE_R);
    q_data.is_ack    = (rx_byte == BYTE_ACK);
    q_data.letter_ok = 1'b1;
    q_data.letter_g  = 1'b0;
    case (rx_byte)
      LET_O: q_data.ack_ev = EV_ACK_O;
      LET_T: q_data.ack_ev = EV_ACK_T;
      LET_E: q_data.ack_ev = EV_ACK_E;
      LET_C: q_data.ack_ev = EV_ACK_C;
      LET_S: q_data.ack_ev = EV_ACK_S;
      LET_G: q_data.letter_g = 1'b1;
      default: q_data.letter_ok = 1'b0;
    endcase
  end

endmodule

// ----- sv/ard_queue.sv -----
// Short command queue between front end and deframer back end
module ard_queue
  import ard_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_data
);

  cmd_t               mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ard_back.sv -----
// Back end: frame state machine, pending read FIFO and result register
module ard_back
  import ard_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         event_res,
  output logic [2:0]         read_kind,
  output logic [15:0]        word_index,
  output logic signed [31:0] word_value,
  output logic               last_word
);

  phase_t                phase, phase_next;
  logic [3:0]            letter_ev, letter_ev_next;
  logic                  letter_g, letter_g_next;
  logic                  unmatched, unmatched_next;
  logic [15:0]           payload_length, payload_length_next;
  logic [15:0]           byte_counter, byte_counter_next;
  logic [15:0]           word_counter, word_counter_next;
  logic [31:0]           word_assembly, word_assembly_next;

  logic [2:0]            pend_mem [PENDING_DEPTH];
  logic [PEND_PTR_W-1:0] pend_head;
  logic [PEND_CNT_W-1:0] pend_count;
  logic [PEND_PTR_W:0]   tail_sum;
  logic [PEND_PTR_W-1:0] pend_tail;
  logic                  push, pop;

  logic                  take;
  logic                  emit;
  logic [3:0]            ev;
  logic [2:0]            ev_kind;
  logic [15:0]           ev_idx;
  logic [31:0]           ev_val;
  logic                  ev_last;

  logic [2:0]            head_kind;
  logic [1:0]            pos;
  logic                  word_done;
  logic [15:0]           words_total;
  logic [16:0]           bc_inc;
  logic [16:0]           wc_inc;
  logic [31:0]           merged;

  assign take  = q_valid && (!out_valid || out_ready);
  assign q_pop = take;

  assign head_kind = pend_mem[pend_head];
  assign tail_sum  = {1'b0, pend_head} + (PEND_PTR_W + 1)'(pend_count);
  assign pend_tail = (tail_sum >= (PEND_PTR_W + 1)'(PENDING_DEPTH))
                   ? PEND_PTR_W'(tail_sum - (PEND_PTR_W + 1)'(PENDING_DEPTH))
                   : PEND_PTR_W'(tail_sum);

  assign bc_inc = {1'b0, byte_counter} + 17'd1;
  assign wc_inc = {1'b0, word_counter} + 17'd1;

  always_comb begin
    case (head_kind)
      KIND_SPEED: begin
        pos         = {1'b0, byte_counter[0]};
        word_done   = byte_counter[0];
        words_total = payload_length >> 1;
      end
      KIND_STATUS: begin
        pos         = 2'd0;
        word_done   = 1'b1;
        words_total = payload_length;
      end
      default: begin
        pos         = byte_counter[1:0];
        word_done   = (byte_counter[1:0] == 2'd3);
        words_total = payload_length >> 2;
      end
    endcase
    if (head_kind == KIND_STATUS) begin
      merged = {31'd0, q_data.data[4]};
    end else begin
      merged = word_assembly | ({24'd0, q_data.data} << {pos, 3'b000});
    end
  end

  always_comb begin
    phase_next          = phase;
    letter_ev_next      = letter_ev;
    letter_g_next       = letter_g;
    unmatched_next      = unmatched;
    payload_length_next = payload_length;
    byte_counter_next   = byte_counter;
    word_counter_next   = word_counter;
    word_assembly_next  = word_assembly;
    push                = 1'b0;
    pop                 = 1'b0;
    emit                = 1'b0;
    ev                  = EV_FRAME_ERR;
    ev_kind             = KIND_NONE;
    ev_idx              = '0;
    ev_val              = '0;
    ev_last             = 1'b0;
    if (take) begin
      if (q_data.is_note) begin
        push = (pend_count != PEND_CNT_W'(PENDING_DEPTH));
      end else begin
        case (phase)
          PH_HUNT: begin
            if (q_data.is_r) begin
              phase_next = PH_LETTER;
            end
          end
          PH_LETTER: begin
            if (!q_data.letter_ok) begin
              emit       = 1'b1;
              phase_next = q_data.is_r ? PH_LETTER : PH_HUNT;
            end else begin
              letter_ev_next = q_data.ack_ev;
              letter_g_next  = q_data.letter_g;
              phase_next     = PH_ACKB;
            end
          end
          PH_ACKB: begin
            if (!q_data.is_ack) begin
              emit       = 1'b1;
              phase_next = q_data.is_r ? PH_LETTER : PH_HUNT;
            end else if (letter_g) begin
              unmatched_next = (pend_count == '0);
              phase_next     = PH_LENLO;
            end else begin
              byte_counter_next = '0;
              phase_next        = PH_TRAIL;
            end
          end
          PH_LENLO: begin
            payload_length_next = {8'd0, q_data.data};
            phase_next          = PH_LENHI;
          end
          PH_LENHI: begin
            payload_length_next = {q_data.data, payload_length[7:0]};
            byte_counter_next   = '0;
            word_counter_next   = '0;
            word_assembly_next  = '0;
            phase_next = ({q_data.data, payload_length[7:0]} != 16'd0) ? PH_PAYLOAD : PH_TRAIL;
          end
          PH_PAYLOAD: begin
            if (!unmatched) begin
              word_assembly_next = merged;
              if (word_done) begin
                emit               = 1'b1;
                ev                 = EV_DATA;
                ev_kind            = head_kind;
                ev_idx             = word_counter;
                ev_val             = merged;
                ev_last            = (wc_inc == {1'b0, words_total});
                word_counter_next  = wc_inc[15:0];
                word_assembly_next = '0;
              end
            end
            byte_counter_next = bc_inc[15:0];
            if (bc_inc >= {1'b0, payload_length}) begin
              byte_counter_next = '0;
              phase_next        = PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            byte_counter_next = bc_inc[15:0];
            if (bc_inc >= 17'd2) begin
              byte_counter_next = '0;
              phase_next        = PH_HUNT;
              if (!letter_g) begin
                emit = 1'b1;
                ev   = letter_ev;
              end else if (unmatched) begin
                unmatched_next = 1'b0;
                emit           = 1'b1;
                ev             = EV_UNMATCHED;
                ev_last        = 1'b1;
              end else begin
                pop = 1'b1;
                if (word_counter == '0) begin
                  emit    = 1'b1;
                  ev      = EV_EMPTY;
                  ev_kind = head_kind;
                  ev_last = 1'b1;
                end
              end
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend_mem[pend_tail] <= q_data.kind;
    end
  end

  always_ff @(posedge clk) begin
    letter_ev      <= letter_ev_next;
    letter_g       <= letter_g_next;
    unmatched      <= unmatched_next;
    payload_length <= payload_length_next;
    byte_counter   <= byte_counter_next;
    word_counter   <= word_counter_next;
    word_assembly  <= word_assembly_next;
    if (take && emit) begin
      event_res  <= ev;
      read_kind  <= ev_kind;
      word_index <= ev_idx;
      word_value <= ev_val;
      last_word  <= ev_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      pend_head  <= '0;
      pend_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase <= phase_next;
      if (push) begin
        pend_count <= pend_count + 1'b1;
      end else if (pop) begin
        pend_count <= pend_count - 1'b1;
        pend_head  <= (pend_head == PEND_PTR_W'(PENDING_DEPTH - 1)) ? '0 : pend_head + 1'b1;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/actuator_response_deframer_top.sv -----
// Top level of the actuator response deframer
// Path: a byte accepted is written into the command queue, and any result it produces is
// held in the back end's result register before it shows on the outputs.
// Throughput: one transaction per cycle; in_ready falls only when the 4-entry
// command queue between front end and back end is full.
// Reset (rst, synchronous): hunting for 'R', queues empty, no result pending.
module actuator_response_deframer_top
  import ard_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  input  logic [2:0]         request_kind,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         event_res,
  output logic [2:0]         read_kind,
  output logic [15:0]        word_index,
  output logic signed [31:0] word_value,
  output logic               last_word
);

  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t q_in, q_out;

  ard_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .request_kind (request_kind),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  ard_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  ard_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .read_kind  (read_kind),
    .word_index (word_index),
    .word_value (word_value),
    .last_word  (last_word)
  );

endmodule

// ----- sv/ard_checker.sv -----
// Port-level checks of the deframer, bound to the top level
`include "actuator_response_deframer_top_defines.svh"

module ard_checker
  import ard_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         event_res,
  input logic [2:0]         read_kind,
  input logic [15:0]        word_index,
  input logic signed [31:0] word_value,
  input logic               last_word
);

  logic held;
  logic non_data;
  logic plain_ev;

  assign held     = out_valid && !out_ready;
  assign non_data = out_valid && (event_res != EV_DATA);
  assign plain_ev = out_valid && (event_res <= EV_ACK_S || event_res == EV_FRAME_ERR);

  `ARD_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(event_res) && $stable(word_value))
  `ARD_ASSERT_NOW(a_non_data_zero, non_data, word_index == '0 && word_value == '0)
  `ARD_ASSERT_NOW(a_unmatched_last, out_valid && event_res == EV_UNMATCHED, last_word && read_kind == KIND_NONE)
  `ARD_ASSERT_NOW(a_ack_plain, plain_ev, !last_word && read_kind == KIND_NONE)

endmodule

bind actuator_response_deframer_top ard_checker u_ard_checker (.*);
